// ----- design/resp_request_parser_assert.svh -----
// Assertion macros shared by the parser RTL.
`ifndef RESP_REQUEST_PARSER_ASSERT_SVH
`define RESP_REQUEST_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RRP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("resp_request_parser: same-cycle check failed");
`define RRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("resp_request_parser: next-cycle check failed");
`else
`define RRP_ASSERT_NOW(label, ante, cons)
`define RRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/rrp_pkg.sv -----
// Types and constants of the request parser.
`default_nettype none

package rrp_pkg;

   localparam int unsigned COUNT_W  = 21;
   localparam int unsigned INDEX_W  = 20;
   localparam int unsigned LENGTH_W = 30;
   localparam int unsigned CSR_W    = 30;

   localparam logic [7:0] CH_MULTI = 8'h2A;
   localparam logic [7:0] CH_BULK  = 8'h24;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [LENGTH_W-1:0] NUM_SAT   = {LENGTH_W{1'b1}};
   localparam logic [COUNT_W-1:0]  INDEX_CAP = COUNT_W'(1) << INDEX_W;

   localparam logic [COUNT_W-1:0]  MAX_COUNT_RESET  = 21'd1048576;
   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 30'd536870912;

   localparam logic CSR_MAX_ARG_COUNT  = 1'b0;
   localparam logic CSR_MAX_ARG_LENGTH = 1'b1;

   localparam logic [1:0] EV_FRAME    = 2'd0;
   localparam logic [1:0] EV_PAYLOAD  = 2'd1;
   localparam logic [1:0] EV_ARG_DONE = 2'd2;
   localparam logic [1:0] EV_ERROR    = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_HEADER = 2'd1;
   localparam logic [1:0] ERR_MARKER = 2'd2;
   localparam logic [1:0] ERR_LENGTH = 2'd3;

   typedef enum logic [7:0] {
      PH_HDR_MARK = 8'b0000_0001,
      PH_HDR_SIGN = 8'b0000_0010,
      PH_HDR_NUM  = 8'b0000_0100,
      PH_LEN_MARK = 8'b0000_1000,
      PH_LEN_SIGN = 8'b0001_0000,
      PH_LEN_NUM  = 8'b0010_0000,
      PH_PAYLOAD  = 8'b0100_0000,
      PH_TRAILER  = 8'b1000_0000
   } phase_type;

endpackage

`default_nettype wire

// ----- design/rrp_channels_if.sv -----
// Valid/ready channel interfaces for request bytes and parser results.
`default_nettype none

interface rrp_req_if import rrp_pkg::*;;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface rrp_rsp_if import rrp_pkg::*;;
   logic                valid;
   logic                ready;
   logic [1:0]          event_res;
   logic [7:0]          data_byte;
   logic [INDEX_W-1:0]  arg_index;
   logic [LENGTH_W-1:0] arg_length;
   logic                request_done;
   logic [1:0]          error_code;

   modport source (output valid, output event_res, output data_byte, output arg_index,
                   output arg_length, output request_done, output error_code,
                   input ready);
   modport sink   (input valid, input event_res, input data_byte, input arg_index,
                   input arg_length, input request_done, input error_code,
                   output ready);
endinterface

`default_nettype wire

// ----- design/resp_request_parser.sv -----
// Byte-serial parser for multibulk client requests, with its result register.
//
// The parser takes one request byte per beat and gives exactly one result beat for
// every byte, in the cycle after acceptance. It sustains one byte per cycle while the
// result side keeps up: the whole parse step (line tracking, decimal accumulation by
// ten, limit compares and argument counting) is done in the cycle of acceptance, and
// the result is held in a single output register. req_ch.ready is high whenever that
// register is empty or is being emptied in the same cycle, so a stall on the result
// side holds the input side back by at most the one occupied register. The user
// must write the limits via the csr_ port only while no beat is in flight; not enforced.
`default_nettype none
`include "resp_request_parser_assert.svh"

module resp_request_parser import rrp_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   rrp_req_if.sink                  req_ch,
   rrp_rsp_if.source                rsp_ch,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [CSR_W-1:0]    csr_data
);

   // Configuration registers.
   logic [COUNT_W-1:0]  max_count_ff;
   logic [LENGTH_W-1:0] max_length_ff;

   // Parser state.
   phase_type           phase_ff, phase_in;
   logic                marker_ok_ff, marker_ok_in;
   logic                saw_cr_ff, saw_cr_in;
   logic [LENGTH_W-1:0] accum_ff, accum_in;
   logic                overflow_ff, overflow_in;
   logic                negative_ff, negative_in;
   logic                digits_ended_ff, digits_ended_in;
   logic [COUNT_W-1:0]  args_expected_ff, args_expected_in;
   logic [INDEX_W-1:0]  args_done_ff, args_done_in;
   logic [LENGTH_W-1:0] bytes_left_ff, bytes_left_in;
   logic [LENGTH_W-1:0] cur_length_ff, cur_length_in;
   // Set once the first of the two trailer bytes has gone by.
   logic                trailer_second_ff, trailer_second_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          event_ff, event_in;
   logic [7:0]          data_ff, data_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                done_ff, done_in;
   logic [1:0]          error_ff, error_in;

   logic                accept;
   logic [7:0]          b;
   logic                is_digit;
   logic [33:0]         accum_times_ten;
   logic                take_digit;
   logic                is_header;
   logic [COUNT_W-1:0]  count_limit;
   logic                count_bad;
   logic                length_bad;
   logic [COUNT_W-1:0]  args_done_plus;

   // The result register frees itself in the cycle it is taken, so a new byte can
   // enter on every cycle in which the downstream side keeps up.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.byte_in;

   assign is_digit        = (b >= CH_ZERO) && (b <= CH_NINE);
   // Times ten as two shifted copies, then the digit added.
   assign accum_times_ten = 34'({accum_ff, 3'b000}) + 34'({accum_ff, 1'b0})
                          + 34'(b - CH_ZERO);

   assign is_header = (phase_ff == PH_HDR_MARK) || (phase_ff == PH_HDR_SIGN)
                   || (phase_ff == PH_HDR_NUM);

   // The count limit can never exceed the size of the argument index.
   assign count_limit = (max_count_ff > INDEX_CAP) ? INDEX_CAP : max_count_ff;
   assign count_bad   = !marker_ok_ff || negative_ff || overflow_ff
                     || (accum_ff == '0) || (accum_ff > LENGTH_W'(count_limit));
   // A minus sign is harmless on a zero length.
   assign length_bad  = (negative_ff && (accum_ff != '0)) || overflow_ff
                     || (accum_ff > max_length_ff);

   assign args_done_plus = COUNT_W'(args_done_ff) + COUNT_W'(1);

   always_comb begin
      phase_in          = phase_ff;
      marker_ok_in      = marker_ok_ff;
      saw_cr_in         = saw_cr_ff;
      accum_in          = accum_ff;
      overflow_in       = overflow_ff;
      negative_in       = negative_ff;
      digits_ended_in   = digits_ended_ff;
      args_expected_in  = args_expected_ff;
      args_done_in      = args_done_ff;
      bytes_left_in     = bytes_left_ff;
      cur_length_in     = cur_length_ff;
      trailer_second_in = trailer_second_ff;
      event_in          = EV_FRAME;
      data_in           = '0;
      index_in          = '0;
      length_in         = '0;
      done_in           = 1'b0;
      error_in          = ERR_NONE;
      take_digit        = 1'b0;

      case (phase_ff)
         PH_PAYLOAD: begin
            event_in      = EV_PAYLOAD;
            data_in       = b;
            index_in      = args_done_ff;
            length_in     = cur_length_ff;
            bytes_left_in = bytes_left_ff - LENGTH_W'(1);
            // Payload is entered only with a nonzero count, so one left means last.
            if (bytes_left_ff == LENGTH_W'(1)) begin
               phase_in          = PH_TRAILER;
               trailer_second_in = 1'b0;
            end
         end
         PH_TRAILER: begin
            if (!trailer_second_ff) begin
               trailer_second_in = 1'b1;
            end else begin
               event_in  = EV_ARG_DONE;
               index_in  = args_done_ff;
               length_in = cur_length_ff;
               done_in   = (args_done_plus >= args_expected_ff);
               marker_ok_in      = 1'b0;
               saw_cr_in         = 1'b0;
               accum_in          = '0;
               overflow_in       = 1'b0;
               negative_in       = 1'b0;
               digits_ended_in   = 1'b0;
               trailer_second_in = 1'b0;
               cur_length_in     = '0;
               if (args_done_plus >= args_expected_ff) begin
                  phase_in         = PH_HDR_MARK;
                  args_expected_in = '0;
                  args_done_in     = '0;
                  bytes_left_in    = '0;
               end else begin
                  phase_in     = PH_LEN_MARK;
                  args_done_in = args_done_plus[INDEX_W-1:0];
               end
            end
         end
         PH_HDR_MARK, PH_HDR_SIGN, PH_HDR_NUM,
         PH_LEN_MARK, PH_LEN_SIGN, PH_LEN_NUM: begin
            if (saw_cr_ff && (b == CH_LF)) begin
               // End of a line: every path starts the next line afresh.
               marker_ok_in    = 1'b0;
               saw_cr_in       = 1'b0;
               accum_in        = '0;
               overflow_in     = 1'b0;
               negative_in     = 1'b0;
               digits_ended_in = 1'b0;
               if (is_header && !count_bad) begin
                  args_expected_in = LENGTH_W'(accum_ff) <= LENGTH_W'(INDEX_CAP)
                                   ? accum_ff[COUNT_W-1:0] : INDEX_CAP;
                  args_done_in     = '0;
                  phase_in         = PH_LEN_MARK;
               end else if (!is_header && marker_ok_ff && !length_bad) begin
                  cur_length_in = accum_ff;
                  bytes_left_in = accum_ff;
                  if (accum_ff == '0) begin
                     phase_in          = PH_TRAILER;
                     trailer_second_in = 1'b0;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  // Rejected line: report and go back to waiting for a header.
                  event_in          = EV_ERROR;
                  error_in          = is_header ? ERR_HEADER
                                    : (!marker_ok_ff ? ERR_MARKER : ERR_LENGTH);
                  phase_in          = PH_HDR_MARK;
                  args_expected_in  = '0;
                  args_done_in      = '0;
                  bytes_left_in     = '0;
                  cur_length_in     = '0;
                  trailer_second_in = 1'b0;
               end
            end else begin
               saw_cr_in = (b == CH_CR);
               if ((phase_ff == PH_HDR_MARK) || (phase_ff == PH_LEN_MARK)) begin
                  marker_ok_in = is_header ? (b == CH_MULTI) : (b == CH_BULK);
                  phase_in     = is_header ? PH_HDR_SIGN : PH_LEN_SIGN;
               end else if ((phase_ff == PH_HDR_SIGN) || (phase_ff == PH_LEN_SIGN)) begin
                  phase_in = is_header ? PH_HDR_NUM : PH_LEN_NUM;
                  if (b == CH_MINUS) begin
                     negative_in = 1'b1;
                  end else if (b != CH_PLUS) begin
                     take_digit = 1'b1;
                  end
               end else begin
                  take_digit = 1'b1;
               end
               // Digits accumulate until the first non-digit; the number saturates.
               if (take_digit && !digits_ended_ff) begin
                  if (!is_digit) begin
                     digits_ended_in = 1'b1;
                  end else if (!overflow_ff) begin
                     if (accum_times_ten > 34'(NUM_SAT)) begin
                        overflow_in = 1'b1;
                        accum_in    = NUM_SAT;
                     end else begin
                        accum_in = accum_times_ten[LENGTH_W-1:0];
                     end
                  end
               end
            end
         end
         default: begin
            phase_in = PH_HDR_MARK;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff  <= MAX_COUNT_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ARG_COUNT:  max_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_MAX_ARG_LENGTH: max_length_ff <= csr_data[LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HDR_MARK;
         marker_ok_ff      <= 1'b0;
         saw_cr_ff         <= 1'b0;
         accum_ff          <= '0;
         overflow_ff       <= 1'b0;
         negative_ff       <= 1'b0;
         digits_ended_ff   <= 1'b0;
         args_expected_ff  <= '0;
         args_done_ff      <= '0;
         bytes_left_ff     <= '0;
         cur_length_ff     <= '0;
         trailer_second_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff          <= phase_in;
            marker_ok_ff      <= marker_ok_in;
            saw_cr_ff         <= saw_cr_in;
            accum_ff          <= accum_in;
            overflow_ff       <= overflow_in;
            negative_ff       <= negative_in;
            digits_ended_ff   <= digits_ended_in;
            args_expected_ff  <= args_expected_in;
            args_done_ff      <= args_done_in;
            bytes_left_ff     <= bytes_left_in;
            cur_length_ff     <= cur_length_in;
            trailer_second_ff <= trailer_second_in;
         end
      end
   end

   // Result payload carries no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= event_in;
         data_ff   <= data_in;
         index_ff  <= index_in;
         length_ff <= length_in;
         done_ff   <= done_in;
         error_ff  <= error_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.event_res    = event_ff;
   assign rsp_ch.data_byte    = data_ff;
   assign rsp_ch.arg_index    = index_ff;
   assign rsp_ch.arg_length   = length_ff;
   assign rsp_ch.request_done = done_ff;
   assign rsp_ch.error_code   = error_ff;

   // An error code goes with an error beat and with nothing else.
   `RRP_ASSERT_NOW(a_error_code_match, rsp_valid_ff,
      ((event_ff == EV_ERROR) == (error_ff != ERR_NONE)))
   // The end of a request is only ever flagged on an argument-complete beat.
   `RRP_ASSERT_NOW(a_done_with_arg, rsp_valid_ff && done_ff, (event_ff == EV_ARG_DONE))
   // Payload data appears on payload beats only.
   `RRP_ASSERT_NOW(a_data_only_payload, rsp_valid_ff && (event_ff != EV_PAYLOAD),
      (data_ff == '0))
   // Any accepted byte that raises an error sends the parser back to the header.
   `RRP_ASSERT_NEXT(a_error_to_header, accept && (event_in == EV_ERROR),
      (phase_ff == PH_HDR_MARK))
   // While in payload there is always at least one byte still to come.
   `RRP_ASSERT_NOW(a_payload_nonempty, phase_ff == PH_PAYLOAD, (bytes_left_ff != '0))

endmodule

`default_nettype wire
